[rtl/timed_event_queue_defines.svh]
`ifndef TIMED_EVENT_QUEUE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DEFINES_SVH

// Assertion helpers
`define TEQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define TEQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

[rtl/teq_pkg.sv]
package teq_pkg;

  localparam int unsigned DefQueueDepth = 64;
  localparam int unsigned TimeW = 64;
  localparam int unsigned LenW = 32;
  localparam int unsigned TagW = 16;
  localparam int unsigned CntW = 32;
  localparam int unsigned EntryW = TimeW + LenW + TagW;

  localparam logic [1:0] CfgEarlyMode = 2'd0;
  localparam logic [1:0] CfgTieAfter = 2'd1;
  localparam logic [1:0] CfgFetchStart = 2'd2;

  localparam logic [1:0] EarlyDiscard = 2'd0;
  localparam logic [1:0] EarlyAsap = 2'd2;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StFull = 3'd1;
  localparam logic [2:0] StFetched = 3'd2;
  localparam logic [2:0] StNone = 3'd3;
  localparam logic [2:0] StBalk = 3'd4;

endpackage

[rtl/teq_ram.sv]
module teq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/timed_event_queue.sv]
// Sorted event queue held in one RAM of QueueDepth entries (time, length, tag).
// One item at a time. Every operation walks the RAM with one read and at most one
// write a cycle; each step is a read state, then a compare and write-back state.
// An insert scans from the head for its slot, then shifts the later entries up
// from the tail. A fetch scans for the first ready entry, then shifts the rest
// down; each discarded head also makes the rest shift down. The result is held in
// an output register; a new item is taken once it is shown.
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [1:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [63:0]           event_time_i,
  input  logic [31:0]           event_length_i,
  input  logic [15:0]           event_tag_i,
  input  logic [63:0]           window_min_i,
  input  logic [63:0]           window_max_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic [63:0]           out_time_o,
  output logic [31:0]           out_length_o,
  output logic [15:0]           out_tag_o,
  output logic [6:0]            queue_count_o,
  output logic [31:0]           discarded_count_o,
  output logic [31:0]           asap_count_o,
  output logic [31:0]           late_skip_count_o
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned FW = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_POS_RD, S_POS_CMP, S_INS_RD, S_INS_CMP, S_HEAD_RD, S_HEAD_CMP,
    S_SCAN_RD, S_SCAN_CMP, S_SH_RD, S_SH_WR, S_OUT
  } state_e;

  state_e state_q;
  logic [1:0] early_q;
  logic tie_q, by_start_q;
  logic [FW-1:0] fill_q;
  logic [CntW-1:0] disc_q, asap_q, skip_q;
  logic [FW-1:0] idx_q;
  logic [FW-1:0] pos_q;
  logic [TimeW-1:0] t_q, wmin_q, wmax_q;
  logic [LenW-1:0] len_q;
  logic [TagW-1:0] tag_q;
  logic [2:0] st_q;
  logic [TimeW-1:0] ot_q;
  logic [LenW-1:0] ol_q;
  logic [TagW-1:0] og_q;
  logic ov_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [TimeW-1:0] r_time;
  logic [LenW-1:0] r_len;
  logic [TagW-1:0] r_tag;
  logic [TimeW:0] r_end;
  logic ins_here, ready;

  teq_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign {r_time, r_len, r_tag} = rdata;
  assign r_end = {1'b0, r_time} + {{(TimeW - LenW + 1){1'b0}}, r_len};
  assign ins_here = tie_q ? (r_time <= t_q) : (r_time < t_q);
  assign ready = by_start_q ? (r_time < wmax_q) : (r_end < {1'b0, wmax_q});

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    case (state_q)
      S_POS_RD: raddr = AW'(idx_q);
      S_INS_RD: raddr = AW'(idx_q - FW'(1));
      S_INS_CMP: begin
        we = 1'b1;
        waddr = AW'(idx_q);
        if (idx_q == pos_q) begin
          wdata = {t_q, len_q, tag_q};
        end
      end
      S_HEAD_CMP: begin
        if (r_time < wmin_q && early_q == EarlyAsap) begin
          we = 1'b1;
          wdata = {wmin_q, r_len, r_tag};
        end
      end
      S_SCAN_RD: raddr = AW'(idx_q);
      S_SH_RD: raddr = AW'(idx_q + FW'(1));
      S_SH_WR: begin
        we = 1'b1;
        waddr = AW'(idx_q);
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      early_q <= '0;
      tie_q <= 1'b0;
      by_start_q <= 1'b0;
      fill_q <= '0;
      disc_q <= '0;
      asap_q <= '0;
      skip_q <= '0;
      ov_q <= 1'b0;
      idx_q <= '0;
      pos_q <= '0;
      t_q <= '0;
      len_q <= '0;
      tag_q <= '0;
      wmin_q <= '0;
      wmax_q <= '0;
      st_q <= '0;
      ot_q <= '0;
      ol_q <= '0;
      og_q <= '0;
      status_o <= '0;
      out_time_o <= '0;
      out_length_o <= '0;
      out_tag_o <= '0;
      queue_count_o <= '0;
      discarded_count_o <= '0;
      asap_count_o <= '0;
      late_skip_count_o <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            case (cfg_index_i)
              CfgEarlyMode: early_q <= cfg_data_i;
              CfgTieAfter: tie_q <= cfg_data_i[0];
              CfgFetchStart: by_start_q <= cfg_data_i[0];
              default: ;
            endcase
          end
          if (in_valid_i) begin
            t_q <= event_time_i;
            len_q <= event_length_i;
            tag_q <= event_tag_i;
            wmin_q <= window_min_i;
            wmax_q <= window_max_i;
            ot_q <= '0;
            ol_q <= '0;
            og_q <= '0;
            if (!func_i) begin
              if (fill_q >= FW'(QueueDepth)) begin
                st_q <= StFull;
                state_q <= S_OUT;
              end else begin
                idx_q <= '0;
                pos_q <= '0;
                state_q <= (fill_q == '0) ? S_INS_CMP : S_POS_RD;
              end
            end else begin
              state_q <= (fill_q == '0) ? S_OUT : S_HEAD_RD;
              st_q <= StNone;
            end
          end
        end
        S_POS_RD: state_q <= S_POS_CMP;
        S_POS_CMP: begin
          if (ins_here) begin
            if (idx_q + FW'(1) >= fill_q) begin
              pos_q <= fill_q;
              idx_q <= fill_q;
              state_q <= S_INS_CMP;
            end else begin
              idx_q <= idx_q + FW'(1);
              state_q <= S_POS_RD;
            end
          end else begin
            pos_q <= idx_q;
            idx_q <= fill_q;
            state_q <= S_INS_RD;
          end
        end
        S_INS_RD: state_q <= S_INS_CMP;
        S_INS_CMP: begin
          if (idx_q != pos_q) begin
            idx_q <= idx_q - FW'(1);
            state_q <= (idx_q - FW'(1) == pos_q) ? S_INS_CMP : S_INS_RD;
          end else begin
            fill_q <= fill_q + FW'(1);
            st_q <= StInserted;
            state_q <= S_OUT;
          end
        end
        S_HEAD_RD: state_q <= S_HEAD_CMP;
        S_HEAD_CMP: begin
          if (r_time < wmin_q) begin
            if (early_q == EarlyDiscard) begin
              disc_q <= disc_q + CntW'(1);
              idx_q <= '0;
              st_q <= StNone;
              state_q <= S_SH_RD;
            end else if (early_q == EarlyAsap) begin
              asap_q <= asap_q + CntW'(1);
              idx_q <= '0;
              state_q <= S_SCAN_RD;
            end else begin
              st_q <= StBalk;
              state_q <= S_OUT;
            end
          end else begin
            idx_q <= '0;
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (ready) begin
            st_q <= StFetched;
            ot_q <= r_time;
            ol_q <= r_len;
            og_q <= r_tag;
            state_q <= S_SH_RD;
          end else begin
            skip_q <= skip_q + CntW'(1);
            if (idx_q + FW'(1) >= fill_q) begin
              st_q <= StNone;
              state_q <= S_OUT;
            end else begin
              idx_q <= idx_q + FW'(1);
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_SH_RD: begin
          if (idx_q + FW'(1) >= fill_q) begin
            fill_q <= fill_q - FW'(1);
            if (st_q == StFetched) begin
              state_q <= S_OUT;
            end else begin
              state_q <= (fill_q == FW'(1)) ? S_OUT : S_HEAD_RD;
            end
          end else begin
            state_q <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          idx_q <= idx_q + FW'(1);
          state_q <= S_SH_RD;
        end
        S_OUT: begin
          if (!ov_q || !out_stall_i) begin
            ov_q <= 1'b1;
            status_o <= st_q;
            out_time_o <= ot_q;
            out_length_o <= ol_q;
            out_tag_o <= og_q;
            queue_count_o <= 7'(fill_q);
            discarded_count_o <= disc_q;
            asap_count_o <= asap_q;
            late_skip_count_o <= skip_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (ov_q && !out_stall_i && !(state_q == S_OUT)) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;

endmodule

[rtl/teq_checker.sv]
`include "timed_event_queue_defines.svh"

module teq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [6:0] queue_count_o
);

  `TEQ_ASSERT(a_status_range, clk_i, rst_ni, !out_valid_o || status_o <= 3'd4, "bad status")
  `TEQ_ASSERT(a_count_range, clk_i, rst_ni, !out_valid_o || queue_count_o <= 7'd64,
              "count too high")
  `TEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(status_o), "stalled result changed")
  `TEQ_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o,
                   "item taken while busy")

endmodule

bind timed_event_queue teq_checker u_teq_checker (.*);

[bench/tb_timed_event_queue.sv]
module tb_timed_event_queue;
  import teq_pkg::*;

  localparam int unsigned Depth = DefQueueDepth;
  localparam logic [1:0] EarlyBalk = 2'd1;
  localparam logic [1:0] EarlyReserved = 2'd3;
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam bit FnInsert = 1'b0;
  localparam bit FnFetch = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] ev_time;
    logic [31:0] ev_len;
    logic [15:0] ev_tag;
    logic [63:0] wmin;
    logic [63:0] wmax;
  } op_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] ev_time;
    logic [31:0] ev_len;
    logic [15:0] ev_tag;
    logic [6:0]  count;
    logic [31:0] discards;
    logic [31:0] moves;
    logic [31:0] skips;
  } outcome_t;

  typedef bit bool_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [63:0] event_time_i = '0;
  logic [31:0] event_length_i = '0;
  logic [15:0] event_tag_i = '0;
  logic [63:0] window_min_i = '0;
  logic [63:0] window_max_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [63:0] out_time_o;
  logic [31:0] out_length_o;
  logic [15:0] out_tag_o;
  logic [6:0] queue_count_o;
  logic [31:0] discarded_count_o;
  logic [31:0] asap_count_o;
  logic [31:0] late_skip_count_o;

  timed_event_queue dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] q_time [Depth];
  logic [31:0] q_len [Depth];
  logic [15:0] q_tag [Depth];
  int unsigned q_fill;
  logic [31:0] n_discard, n_asap, n_skip;
  logic [1:0] m_early;
  logic m_tie, m_by_start;

  op_t pending_ops[$];
  outcome_t awaited[$];
  int errors = 0;
  bool_t sender_hold;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_op(input op_t o);
    pending_ops.insert(pending_ops.size(), o);
  endtask

  function automatic void drop_entry(input int unsigned pos);
    for (int unsigned k = pos; k + 1 < q_fill; k++) begin
      q_time[k] = q_time[k + 1];
      q_len[k] = q_len[k + 1];
      q_tag[k] = q_tag[k + 1];
    end
    if (q_fill > 0) q_fill--;
  endfunction

  function automatic outcome_t apply_op(input op_t op);
    outcome_t r;
    int unsigned pos;
    logic [64:0] fin;
    bit ready, done;
    r = '0;
    if (op.func == FnInsert) begin
      if (q_fill >= Depth) begin
        r.status = StFull;
      end else begin
        pos = 0;
        while (pos < q_fill && (m_tie ? q_time[pos] <= op.ev_time : q_time[pos] < op.ev_time))
          pos++;
        for (int unsigned k = q_fill; k > pos; k--) begin
          q_time[k] = q_time[k - 1];
          q_len[k] = q_len[k - 1];
          q_tag[k] = q_tag[k - 1];
        end
        q_time[pos] = op.ev_time;
        q_len[pos] = op.ev_len;
        q_tag[pos] = op.ev_tag;
        q_fill++;
        r.status = StInserted;
      end
    end else begin
      done = 1'b0;
      while (!done && q_fill > 0 && q_time[0] < op.wmin) begin
        if (m_early == EarlyDiscard) begin
          n_discard++;
          drop_entry(0);
        end else if (m_early == EarlyAsap) begin
          n_asap++;
          q_time[0] = op.wmin;
        end else begin
          r.status = StBalk;
          done = 1'b1;
        end
      end
      if (!done) begin
        r.status = StNone;
        for (int unsigned i = 0; i < q_fill && !done; i++) begin
          fin = {1'b0, q_time[i]} + {33'b0, q_len[i]};
          ready = m_by_start ? (q_time[i] < op.wmax) : (fin < {1'b0, op.wmax});
          if (ready) begin
            r.status = StFetched;
            r.ev_time = q_time[i];
            r.ev_len = q_len[i];
            r.ev_tag = q_tag[i];
            drop_entry(i);
            done = 1'b1;
          end else begin
            n_skip++;
          end
        end
      end
    end
    r.count = q_fill[6:0];
    r.discards = n_discard;
    r.moves = n_asap;
    r.skips = n_skip;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int unsigned send_gap = 0;
  op_t cur_op;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      awaited.insert(awaited.size(), apply_op(cur_op));
      send_gap = gap_len();
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (send_gap > 0 || sender_hold || pending_ops.size() == 0 || !rst_ni) begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        cur_op = pending_ops.pop_front();
        in_valid_i <= 1'b1;
        func_i <= cur_op.func;
        event_time_i <= cur_op.ev_time;
        event_length_i <= cur_op.ev_len;
        event_tag_i <= cur_op.ev_tag;
        window_min_i <= cur_op.wmin;
        window_max_i <= cur_op.wmax;
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    outcome_t w;
    if (out_valid_o && !out_stall_i) begin
      if (awaited.size() == 0) begin
        report("unexpected item", {61'b0, status_o}, 64'b0);
      end else begin
        w = awaited.pop_front();
        if (status_o !== w.status) report("status", 64'(status_o), 64'(w.status));
        if (out_time_o !== w.ev_time) report("out_time", out_time_o, w.ev_time);
        if (out_length_o !== w.ev_len)
          report("out_length", 64'(out_length_o), 64'(w.ev_len));
        if (out_tag_o !== w.ev_tag) report("out_tag", 64'(out_tag_o), 64'(w.ev_tag));
        if (queue_count_o !== w.count)
          report("queue_count", 64'(queue_count_o), 64'(w.count));
        if (discarded_count_o !== w.discards)
          report("discarded_count", 64'(discarded_count_o), 64'(w.discards));
        if (asap_count_o !== w.moves)
          report("asap_count", 64'(asap_count_o), 64'(w.moves));
        if (late_skip_count_o !== w.skips)
          report("late_skip_count", 64'(late_skip_count_o), 64'(w.skips));
      end
    end
    if (recv_gap > 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      recv_gap = gap_len();
      out_stall_i <= (recv_gap > 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid_i || awaited.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgEarlyMode) m_early = val;
    else if (idx == CfgTieAfter) m_tie = val[0];
    else if (idx == CfgFetchStart) m_by_start = val[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic op_t mk_insert(input logic [63:0] t, input logic [31:0] l,
                                    input logic [15:0] g);
    op_t o;
    o = '0;
    o.func = FnInsert;
    o.ev_time = t;
    o.ev_len = l;
    o.ev_tag = g;
    o.wmin = {$urandom, $urandom};
    o.wmax = {$urandom, $urandom};
    return o;
  endfunction

  function automatic op_t mk_fetch(input logic [63:0] lo, input logic [63:0] hi);
    op_t o;
    o = '0;
    o.func = FnFetch;
    o.ev_time = {$urandom, $urandom};
    o.ev_len = $urandom;
    o.ev_tag = 16'($urandom);
    o.wmin = lo;
    o.wmax = hi;
    return o;
  endfunction

  // times clustered around a moving base so windows hit, with some raw noise
  logic [63:0] base;
  function automatic logic [63:0] near(input int unsigned spread);
    return base + $urandom_range(0, spread);
  endfunction

  task automatic random_phase(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 5)
        add_op(mk_insert({$urandom, $urandom}, $urandom, 16'($urandom)));
      else if (p < 8)
        add_op(mk_fetch({$urandom, $urandom}, {$urandom, $urandom}));
      else if (p < 55)
        add_op(mk_insert(near(200), $urandom_range(0, 40) |
               ($urandom_range(0, 15) == 0 ? 32'hffff_fff0 : 0), 16'($urandom)));
      else begin
        add_op(mk_fetch(near(60), near(300)));
        base += $urandom_range(0, 30);
      end
    end
  endtask

  initial begin
    q_fill = 0;
    n_discard = '0;
    n_asap = '0;
    n_skip = '0;
    m_early = EarlyDiscard;
    m_tie = 1'b0;
    m_by_start = 1'b0;
    sender_hold = 1'b0;
    base = 64'd1000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, ties, overflow, empty fetch, fill to full
    add_op(mk_fetch(64'd0, 64'd0));
    add_op(mk_insert(64'd0, 32'd0, 16'h0000));
    add_op(mk_insert('1, '1, 16'hffff));
    add_op(mk_insert(64'd5, 32'd1, 16'h0001));
    add_op(mk_insert(64'd5, 32'd1, 16'h0002));
    add_op(mk_fetch(64'd0, '1));
    add_op(mk_fetch(64'd0, '1));
    add_op(mk_fetch(64'd0, '1));
    add_op(mk_fetch(64'd0, '1));
    add_op(mk_fetch(64'd0, '1));
    for (int unsigned i = 0; i < Depth + 2; i++)
      add_op(mk_insert(64'd100 + (i % 7), i, i[15:0]));
    wait_drained();

    set_reg(CfgTieAfter, 2'd1);
    set_reg(CfgFetchStart, 2'd1);
    set_reg(CfgEarlyMode, EarlyBalk);
    add_op(mk_insert(64'd101, 32'd9, 16'hbeef));
    add_op(mk_fetch(64'd200, 64'd300));
    add_op(mk_fetch(64'd0, 64'd102));
    wait_drained();

    set_reg(CfgEarlyMode, EarlyAsap);
    add_op(mk_fetch(64'd500, 64'd400));
    add_op(mk_fetch(64'd500, 64'd501));
    wait_drained();

    set_reg(CfgEarlyMode, EarlyDiscard);
    set_reg(CfgUnused, 2'd3);
    add_op(mk_fetch('1, '1));
    wait_drained();

    // random phases over settings
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(CfgEarlyMode, ph == 3 ? EarlyReserved : 2'($urandom_range(0, 2)));
      set_reg(CfgTieAfter, 2'($urandom_range(0, 1)));
      set_reg(CfgFetchStart, 2'($urandom_range(0, 1)));
      random_phase(50);
      while (pending_ops.size() != 0) @(posedge clk_i);
      sender_hold = 1'b1;
      while (awaited.size() != 0 || in_valid_i) @(posedge clk_i);
      sender_hold = 1'b0;
      random_phase(45);
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb_timed_event_queue: done, clean");
    end else begin
      $display("tb_timed_event_queue: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_timed_event_queue: done, errors");
    $finish;
  end

endmodule
